[rtl/modbus_register_write_framer_core_defines.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the Modbus register write framer.
// -----------------------------------------------------------------------------
`ifndef MODBUS_REGISTER_WRITE_FRAMER_CORE_DEFINES_SVH
`define MODBUS_REGISTER_WRITE_FRAMER_CORE_DEFINES_SVH

// Property checked while out of reset.
`define MRWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that also covers the reset cycles.
`define MRWF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mrwf_pkg.sv]
// -----------------------------------------------------------------------------
// mrwf_pkg
// Types, constants, CRC step and microcode program of the write framer.
// -----------------------------------------------------------------------------
package mrwf_pkg;

  // Modbus function codes and fixed pair-write body bytes
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
  localparam logic [7:0] START_ADDR_HI   = 8'h00;
  localparam logic [7:0] START_ADDR_LO   = 8'h00;
  localparam logic [7:0] QUANTITY_HI     = 8'h00;
  localparam logic [7:0] QUANTITY_LO     = 8'h02;
  localparam logic [7:0] BYTE_COUNT      = 8'h04;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register reset values
  localparam logic [7:0]  DEVICE_ID_RST     = 8'h01;
  localparam logic [15:0] REPLY_TIMEOUT_RST = 16'd500;
  localparam logic [3:0]  REPLY_LIMIT_RST   = 4'd8;
  localparam logic [3:0]  REPLY_COUNT_MAX   = 4'd15;

  typedef enum logic [1:0] {
    CFG_DEVICE_ID     = 2'd0,
    CFG_REPLY_TIMEOUT = 2'd1,
    CFG_REPLY_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_PAIR   = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_REPLY  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_DEVICE,
    SRC_CONST,
    SRC_ADDR_HI,
    SRC_ADDR_LO,
    SRC_VAL_HI,
    SRC_VAL_LO,
    SRC_CUR_HI,
    SRC_CUR_LO,
    SRC_CRC_LO,
    SRC_CRC_HI
  } byte_src_t;

  typedef enum logic [1:0] {
    OP_NEXT,   // advance to the following step
    OP_END,    // last step of the run
    OP_JHELD   // jump to single frame if a write is held, else end
  } seq_op_t;

  typedef logic [4:0] step_addr_t;

  localparam step_addr_t STEP_SINGLE = 5'd0;
  localparam step_addr_t STEP_PAIR   = 5'd8;
  localparam step_addr_t STEP_FINISH = 5'd21;

  typedef struct packed {
    byte_src_t  src;
    logic [7:0] konst;
    logic       crc_init;
    logic       crc_feed;
    logic       byte_valid;
    logic       done;
    logic       close;
    logic       opens;
    seq_op_t    op;
  } ctrl_t;

  typedef struct packed {
    logic  fire;
    logic  last;
    ctrl_t ctrl;
  } seq_step_t;

  typedef struct packed {
    logic       go;
    step_addr_t entry;
  } start_t;

  // one CRC-16/Modbus byte update
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic ctrl_t uop(byte_src_t src, logic [7:0] konst, logic init,
                                logic feed, logic opens, seq_op_t op);
    ctrl_t c;
    c.src        = src;
    c.konst      = konst;
    c.crc_init   = init;
    c.crc_feed   = feed;
    c.byte_valid = 1'b1;
    c.done       = 1'b0;
    c.close      = 1'b0;
    c.opens      = opens;
    c.op         = op;
    return c;
  endfunction

  // microcode program
  function automatic ctrl_t rom(step_addr_t pc);
    ctrl_t c;
    c = '{SRC_ZERO, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, OP_END};
    case (pc)
      // single register write
      5'd0:  c = uop(SRC_DEVICE,  8'h00,           1'b1, 1'b1, 1'b0, OP_NEXT);
      5'd1:  c = uop(SRC_CONST,   FC_WRITE_SINGLE, 1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd2:  c = uop(SRC_ADDR_HI, 8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd3:  c = uop(SRC_ADDR_LO, 8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd4:  c = uop(SRC_VAL_HI,  8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd5:  c = uop(SRC_VAL_LO,  8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd6:  c = uop(SRC_CRC_LO,  8'h00,           1'b0, 1'b0, 1'b0, OP_NEXT);
      5'd7:  c = uop(SRC_CRC_HI,  8'h00,           1'b0, 1'b0, 1'b1, OP_END);
      // voltage/current pair write
      5'd8:  c = uop(SRC_DEVICE,  8'h00,           1'b1, 1'b1, 1'b0, OP_NEXT);
      5'd9:  c = uop(SRC_CONST,   FC_WRITE_MULTI,  1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd10: c = uop(SRC_CONST,   START_ADDR_HI,   1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd11: c = uop(SRC_CONST,   START_ADDR_LO,   1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd12: c = uop(SRC_CONST,   QUANTITY_HI,     1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd13: c = uop(SRC_CONST,   QUANTITY_LO,     1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd14: c = uop(SRC_CONST,   BYTE_COUNT,      1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd15: c = uop(SRC_VAL_HI,  8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd16: c = uop(SRC_VAL_LO,  8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd17: c = uop(SRC_CUR_HI,  8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd18: c = uop(SRC_CUR_LO,  8'h00,           1'b0, 1'b1, 1'b0, OP_NEXT);
      5'd19: c = uop(SRC_CRC_LO,  8'h00,           1'b0, 1'b0, 1'b0, OP_NEXT);
      5'd20: c = uop(SRC_CRC_HI,  8'h00,           1'b0, 1'b0, 1'b1, OP_END);
      // exchange end marker, then any held write
      5'd21: c = '{SRC_ZERO, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, OP_JHELD};
      default: c = '{SRC_ZERO, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, OP_END};
    endcase
    return c;
  endfunction

endpackage

[rtl/mrwf_sequencer.sv]
// -----------------------------------------------------------------------------
// mrwf_sequencer
// Step counter over the microcode program, one step per free output slot.
// -----------------------------------------------------------------------------
module mrwf_sequencer
  import mrwf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  start_t    start,
  input  logic      slot_free,
  input  logic      held_valid,
  output logic      running,
  output seq_step_t step
);

  step_addr_t pc;
  ctrl_t      ctrl;

  assign ctrl      = rom(pc);
  assign step.fire = running && slot_free;
  assign step.ctrl = ctrl;
  assign step.last = (ctrl.op == OP_END) || ((ctrl.op == OP_JHELD) && !held_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pc      <= STEP_SINGLE;
    end else if (start.go) begin
      running <= 1'b1;
      pc      <= start.entry;
    end else if (step.fire) begin
      case (ctrl.op)
        OP_NEXT: pc <= pc + 5'd1;
        OP_JHELD: begin
          if (held_valid) begin
            pc <= STEP_SINGLE;
          end else begin
            running <= 1'b0;
          end
        end
        default: running <= 1'b0;
      endcase
    end
  end

endmodule

[rtl/mrwf_datapath.sv]
// -----------------------------------------------------------------------------
// mrwf_datapath
// Config, exchange state, held slot, operands, byte select and CRC.
// -----------------------------------------------------------------------------
module mrwf_datapath
  import mrwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  logic [1:0]  kind,
  input  logic [15:0] reg_address,
  input  logic [15:0] reg_value,
  input  logic [15:0] second_value,
  input  seq_step_t   step,
  output start_t      start,
  output logic        held_valid,
  output logic [7:0]  out_byte
);

  logic [7:0]  device_id;
  logic [15:0] reply_timeout_ticks;
  logic [3:0]  reply_byte_limit;

  logic        busy;
  logic [15:0] elapsed_ticks;
  logic [3:0]  reply_count;
  logic [3:0]  reply_count_next;
  logic [15:0] held_address;
  logic [15:0] held_value;
  logic [15:0] op_addr;
  logic [15:0] op_val;
  logic [15:0] op_cur;
  logic [15:0] crc;
  logic [15:0] crc_base;
  logic        timed_out;

  assign timed_out        = elapsed_ticks >= reply_timeout_ticks;
  assign reply_count_next = (reply_count == REPLY_COUNT_MAX) ? reply_count
                                                             : reply_count + 4'd1;

  // dispatch of an accepted item
  always_comb begin
    start.go    = 1'b0;
    start.entry = STEP_SINGLE;
    if (accept) begin
      case (kind_t'(kind))
        KIND_SINGLE: start.go = !busy;
        KIND_PAIR: begin
          start.go    = 1'b1;
          start.entry = STEP_PAIR;
        end
        KIND_TICK: begin
          start.go    = busy && timed_out;
          start.entry = STEP_FINISH;
        end
        KIND_REPLY: begin
          start.go    = busy && (reply_count_next >= reply_byte_limit);
          start.entry = STEP_FINISH;
        end
        default: start.go = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (step.ctrl.src)
      SRC_DEVICE:  out_byte = device_id;
      SRC_CONST:   out_byte = step.ctrl.konst;
      SRC_ADDR_HI: out_byte = op_addr[15:8];
      SRC_ADDR_LO: out_byte = op_addr[7:0];
      SRC_VAL_HI:  out_byte = op_val[15:8];
      SRC_VAL_LO:  out_byte = op_val[7:0];
      SRC_CUR_HI:  out_byte = op_cur[15:8];
      SRC_CUR_LO:  out_byte = op_cur[7:0];
      SRC_CRC_LO:  out_byte = crc[7:0];
      SRC_CRC_HI:  out_byte = crc[15:8];
      default:     out_byte = 8'h00;
    endcase
  end

  assign crc_base = step.ctrl.crc_init ? CRC_INIT : crc;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      device_id           <= DEVICE_ID_RST;
      reply_timeout_ticks <= REPLY_TIMEOUT_RST;
      reply_byte_limit    <= REPLY_LIMIT_RST;
      busy                <= 1'b0;
      elapsed_ticks       <= 16'd0;
      reply_count         <= 4'd0;
      held_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DEVICE_ID:     device_id           <= cfg_data[7:0];
          CFG_REPLY_TIMEOUT: reply_timeout_ticks <= cfg_data;
          CFG_REPLY_LIMIT:   reply_byte_limit    <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (accept && busy) begin
        case (kind_t'(kind))
          KIND_SINGLE: held_valid <= 1'b1;
          KIND_TICK: begin
            if (!timed_out) elapsed_ticks <= elapsed_ticks + 16'd1;
          end
          KIND_REPLY: reply_count <= reply_count_next;
          default: ;
        endcase
      end
      if (step.fire && step.ctrl.close) begin
        busy       <= 1'b0;
        held_valid <= 1'b0;
      end
      if (step.fire && step.ctrl.opens) begin
        busy          <= 1'b1;
        elapsed_ticks <= 16'd0;
        reply_count   <= 4'd0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_addr <= reg_address;
      op_val  <= reg_value;
      op_cur  <= second_value;
      if (busy && (kind_t'(kind) == KIND_SINGLE)) begin
        held_address <= reg_address;
        held_value   <= reg_value;
      end
    end
    if (step.fire && step.ctrl.close && held_valid) begin
      op_addr <= held_address;
      op_val  <= held_value;
    end
    if (step.fire && step.ctrl.crc_feed) begin
      crc <= crc_byte(crc_base, out_byte);
    end
  end

endmodule

[rtl/modbus_register_write_framer_core.sv]
// -----------------------------------------------------------------------------
// modbus_register_write_framer_core: Modbus RTU write framer, one byte a cycle
// while the sink does not stall. An exchange end also sends any held write; a
// tick/reply byte with no frame starts no run. Input is stalled while a run is
// active. Rate is set by the sequencer's one step (one byte) per cycle while the output slot is free.
// Sync reset: idle, no exchange, slot empty, registers to defaults; no sweep.
// -----------------------------------------------------------------------------
module modbus_register_write_framer_core
  import mrwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] reg_address,
  input  logic [15:0] reg_value,
  input  logic [15:0] second_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  tx_byte,
  output logic        byte_valid,
  output logic        last_of_run,
  output logic        exchange_done
);

  // Control flow:
  //   An input transfer is taken whenever no microcode run is active. Items
  //   that cause no results (held write, tick, reply byte without end) are
  //   finished in the transfer cycle itself. Items that cause results start
  //   the sequencer at an entry point; each step emits one result into the
  //   output register, and a step only fires when that register is free or
  //   being emptied in the same cycle, so a stalled sink simply pauses the
  //   program.

  logic      running;
  logic      accept;
  logic      slot_free;
  logic      held_valid;
  logic [7:0] out_byte;
  start_t    start;
  seq_step_t step;

  assign in_stall  = running;
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  mrwf_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .slot_free  (slot_free),
    .held_valid (held_valid),
    .running    (running),
    .step       (step)
  );

  mrwf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .kind         (kind),
    .reg_address  (reg_address),
    .reg_value    (reg_value),
    .second_value (second_value),
    .step         (step),
    .start        (start),
    .held_valid   (held_valid),
    .out_byte     (out_byte)
  );

  // output register: holds a result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      tx_byte       <= out_byte;
      byte_valid    <= step.ctrl.byte_valid;
      last_of_run   <= step.last;
      exchange_done <= step.ctrl.done;
    end
  end

endmodule

[rtl/mrwf_checker.sv]
// -----------------------------------------------------------------------------
// mrwf_checker
// Port-level checks of the write framer, bound to the top level.
// -----------------------------------------------------------------------------
`include "modbus_register_write_framer_core_defines.svh"

module mrwf_checker
  import mrwf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  kind,
  input logic [15:0] reg_address,
  input logic [15:0] reg_value,
  input logic [15:0] second_value,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  tx_byte,
  input logic        byte_valid,
  input logic        last_of_run,
  input logic        exchange_done
);

  `MRWF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(last_of_run), "stalled result changed")

  `MRWF_ASSERT(a_marker_empty, out_valid && exchange_done |-> !byte_valid && (tx_byte == 8'h00), "end marker carries a byte")

  `MRWF_ASSERT(a_pair_runs, in_valid && !in_stall && (kind == KIND_PAIR) |=> in_stall, "pair write did not start a frame")

  `MRWF_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "result pending after reset")

endmodule

bind modbus_register_write_framer_core mrwf_checker u_mrwf_checker (.*);
